// ----- rtl/dzr_pkg.sv -----
package dzr_pkg;

   // bytes in each run count (2 to 4)
   localparam int unsigned COUNT_BYTES = 4;

   typedef logic [2:0] phase_type;

   localparam phase_type PH_WIDTH  = 3'd0;
   localparam phase_type PH_HEIGHT = 3'd1;
   localparam phase_type PH_EMPTY  = 3'd2;
   localparam phase_type PH_FULL   = 3'd3;
   localparam phase_type PH_LIT    = 3'd4;

   typedef struct packed {
      logic signed [15:0] depth_value;
      logic [31:0]        repeat_count;
      logic               frame_last;
      logic               overrun_error;
   } rsp_type;

   // index of the final byte of the field parsed in a phase
   function automatic logic [1:0] last_index(input phase_type phase);
      logic [1:0] idx;
      case (phase)
         PH_LIT:             idx = 2'd1;
         PH_EMPTY, PH_FULL:  idx = 2'(COUNT_BYTES - 1);
         default:            idx = 2'd3;
      endcase
      return idx;
   endfunction

endpackage

// ----- rtl/dzr_req_if.sv -----
interface dzr_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ----- rtl/dzr_rsp_if.sv -----
interface dzr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] depth_value;
   logic [31:0]        repeat_count;
   logic               frame_last;
   logic               overrun_error;

   modport source (output valid, output depth_value, output repeat_count,
                   output frame_last, output overrun_error, input ready);
   modport sink (input valid, input depth_value, input repeat_count,
                 input frame_last, input overrun_error, output ready);
endinterface

// ----- rtl/depth_zero_run_decoder.sv -----
// Zero-run depth image decoder. Takes the compressed stream one byte word per
// cycle on req_if: a little-endian 32-bit width and height, then pairs of an
// empty count and a full count (dzr_pkg::COUNT_BYTES bytes each) with that many
// 16-bit literals. Each nonzero empty run gives one rsp_if word (value 0 with
// its count) and each literal one word with count 1; the word that completes
// width*height pixels has frame_last set, runs past the frame are clipped and
// flagged with overrun_error. One byte is taken every cycle while rsp_if keeps
// up; a byte goes through an input register and the parse logic, and a result
// is registered in the output register. The widest path is the 32x32
// multiply of width by height, done in the cycle that parses the height's last
// byte. While a result waits on rsp_if, one more byte is held in the input
// register and bytes that give no result keep flowing.
module depth_zero_run_decoder (
   input logic      clock,
   input logic      reset,
   dzr_req_if.sink   req_if,
   dzr_rsp_if.source rsp_if
);

   logic            byte_vld_ff, byte_vld_in;
   logic [7:0]      byte_ff;
   logic            rsp_vld_ff, rsp_vld_in;
   dzr_pkg::rsp_type rsp_ff;
   dzr_pkg::rsp_type result;
   logic            emit;
   logic            step;

   dzr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .data_byte (byte_ff),
      .emit      (emit),
      .result    (result)
   );

   // a byte that gives no result needs no room in the output register
   assign step         = byte_vld_ff && (!emit || !rsp_vld_ff || rsp_if.ready);
   assign req_if.ready = !byte_vld_ff || step;

   always_comb begin
      byte_vld_in = byte_vld_ff;
      if (req_if.valid && req_if.ready) begin
         byte_vld_in = 1'b1;
      end else if (step) begin
         byte_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (step && emit) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         byte_vld_ff <= byte_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         byte_ff <= req_if.data_byte;
      end
      if (step && emit) begin
         rsp_ff <= result;
      end
   end

   assign rsp_if.valid         = rsp_vld_ff;
   assign rsp_if.depth_value   = rsp_ff.depth_value;
   assign rsp_if.repeat_count  = rsp_ff.repeat_count;
   assign rsp_if.frame_last    = rsp_ff.frame_last;
   assign rsp_if.overrun_error = rsp_ff.overrun_error;

`ifndef SYNTH
   // never overwrite a result that has not been taken
   a_no_clobber: assert property (@(posedge clock) disable iff (reset)
      !(step && emit && rsp_vld_ff && !rsp_if.ready))
      else $error("result register overwritten");

   a_byte_held: assert property (@(posedge clock) disable iff (reset)
      (req_if.valid && req_if.ready) |=> byte_vld_ff)
      else $error("accepted byte lost");

   // literals always carry a count of one
   a_literal_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.depth_value != 16'sd0) |-> rsp_ff.repeat_count == 32'd1)
      else $error("literal with count other than one");

   a_past_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && rsp_ff.overrun_error && !rsp_ff.frame_last) |->
      rsp_ff.repeat_count == 32'd1)
      else $error("overrun word past frame with bad count");
`endif

endmodule

// ----- rtl/dzr_parser.sv -----
module dzr_parser (
   input  logic            clock,
   input  logic            reset,
   input  logic            step,
   input  logic [7:0]      data_byte,
   output logic            emit,
   output dzr_pkg::rsp_type result
);

   dzr_pkg::phase_type phase_ff, phase_in;
   logic [1:0]  idx_ff, idx_in;
   logic [23:0] asm_ff, asm_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] total_ff, total_in;
   logic [31:0] pos_ff, pos_in;
   logic [31:0] lits_ff, lits_in;

   logic [31:0] word;
   logic [63:0] prod;
   logic [32:0] sum;
   logic [31:0] left;
   logic [31:0] pos_inc;
   logic [31:0] lits_dec;
   logic        clip;
   logic        in_frame;

   always_comb begin
      word     = {8'h00, asm_ff} | ({24'h000000, data_byte} << {idx_ff, 3'b000});
      prod     = {32'h0, width_ff} * {32'h0, word};
      sum      = {1'b0, pos_ff} + {1'b0, word};
      left     = total_ff - pos_ff;
      clip     = sum > {1'b0, total_ff};
      in_frame = pos_ff < total_ff;
      pos_inc  = pos_ff + 32'd1;
      lits_dec = (lits_ff == 32'd0) ? 32'd0 : lits_ff - 32'd1;

      phase_in = phase_ff;
      idx_in   = idx_ff;
      asm_in   = asm_ff;
      width_in = width_ff;
      total_in = total_ff;
      pos_in   = pos_ff;
      lits_in  = lits_ff;
      emit     = 1'b0;
      result   = '0;

      if (idx_ff != dzr_pkg::last_index(phase_ff)) begin
         idx_in = idx_ff + 2'd1;
         asm_in = word[23:0];
      end else begin
         idx_in = 2'd0;
         asm_in = '0;
         case (phase_ff)
            dzr_pkg::PH_HEIGHT: begin
               total_in = (prod[63:32] != 32'h0) ? 32'hFFFF_FFFF : prod[31:0];
               pos_in   = '0;
               lits_in  = '0;
               phase_in = (width_ff == 32'h0 || word == 32'h0) ?
                          dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
            end
            dzr_pkg::PH_EMPTY: begin
               phase_in = dzr_pkg::PH_FULL;
               if (word != 32'h0) begin
                  // a run past the frame end is cut at the end
                  emit                 = 1'b1;
                  pos_in               = clip ? total_ff : sum[31:0];
                  result.repeat_count  = clip ? left : word;
                  result.frame_last    = clip || (sum[31:0] == total_ff);
                  result.overrun_error = clip;
               end
            end
            dzr_pkg::PH_FULL: begin
               if (word == 32'h0) begin
                  phase_in = (pos_ff >= total_ff) ? dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
               end else begin
                  lits_in  = word;
                  phase_in = dzr_pkg::PH_LIT;
               end
            end
            dzr_pkg::PH_LIT: begin
               emit                 = 1'b1;
               pos_in               = in_frame ? pos_inc : pos_ff;
               lits_in              = lits_dec;
               result.depth_value   = word[15:0];
               result.repeat_count  = 32'd1;
               result.frame_last    = in_frame && (pos_inc == total_ff);
               result.overrun_error = !in_frame;
               if (lits_dec == 32'd0) begin
                  phase_in = (!in_frame || pos_inc == total_ff) ?
                             dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
               end
            end
            default: begin
               width_in = word;
               phase_in = dzr_pkg::PH_HEIGHT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= dzr_pkg::PH_WIDTH;
         idx_ff   <= '0;
         asm_ff   <= '0;
         width_ff <= '0;
         total_ff <= '0;
         pos_ff   <= '0;
         lits_ff  <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         idx_ff   <= idx_in;
         asm_ff   <= asm_in;
         width_ff <= width_in;
         total_ff <= total_in;
         pos_ff   <= pos_in;
         lits_ff  <= lits_in;
      end
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned STALL_LIMIT  = 2000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned STREAM_BYTES = 430;
   localparam logic [31:0] COUNT_MASK   =
      32'hFFFF_FFFF >> (8 * (4 - dzr_pkg::COUNT_BYTES));

   typedef struct {
      logic [7:0] data;
      bit         drain;   // hold this byte until every run word has come back
   } stream_byte_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   dzr_req_if req_bus ();
   dzr_rsp_if rsp_bus ();

   depth_zero_run_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   stream_byte_type   stream_q[$];
   dzr_pkg::rsp_type  expected_runs[$];
   bit                drain_pending;
   int unsigned       stream_total;
   int unsigned       bytes_accepted;
   int                runs_predicted;
   int                runs_checked;
   int unsigned       mismatch_count;
   int unsigned       quiet_cycles;

   // decoder state mirrored on the testbench side
   dzr_pkg::phase_type dec_phase;
   logic [1:0]   dec_index;
   logic [31:0]  dec_word;
   logic [31:0]  frame_w;
   logic [31:0]  frame_total;
   logic [31:0]  pixel_pos;
   logic [31:0]  literals_left;

   task automatic decode_byte(input logic [7:0] b);
      logic [31:0] field;
      logic [63:0] area;
      logic [31:0] room;
      logic [31:0] run_len;
      int unsigned need;
      dzr_pkg::rsp_type run;
      if (dec_phase > dzr_pkg::PH_LIT) dec_phase = dzr_pkg::PH_WIDTH;
      dec_word = dec_word | (32'(b) << (8 * dec_index));
      case (dec_phase)
         dzr_pkg::PH_WIDTH, dzr_pkg::PH_HEIGHT: need = 4;
         dzr_pkg::PH_LIT:                       need = 2;
         default:                               need = dzr_pkg::COUNT_BYTES;
      endcase
      if (dec_index + 1 < need) begin
         dec_index = dec_index + 2'd1;
         return;
      end
      dec_index = '0;
      field = dec_word;
      dec_word = '0;
      run.depth_value   = '0;
      run.repeat_count  = 32'd1;
      run.frame_last    = 1'b0;
      run.overrun_error = 1'b0;
      case (dec_phase)
         dzr_pkg::PH_WIDTH: begin
            frame_w = field;
            dec_phase = dzr_pkg::PH_HEIGHT;
         end
         dzr_pkg::PH_HEIGHT: begin
            area = 64'(frame_w) * 64'(field);
            frame_total = (area > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : area[31:0];
            pixel_pos = '0;
            literals_left = '0;
            dec_phase = (frame_total == 0) ? dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
         end
         dzr_pkg::PH_EMPTY: begin
            dec_phase = dzr_pkg::PH_FULL;
            if (field != 0) begin
               room = (pixel_pos < frame_total) ? frame_total - pixel_pos : 32'd0;
               run_len = field;
               if (field > room) begin
                  run_len = room;
                  run.overrun_error = 1'b1;
               end
               pixel_pos = pixel_pos + run_len;
               run.repeat_count = run_len;
               run.frame_last = (pixel_pos >= frame_total);
               expected_runs = {expected_runs, run};
               runs_predicted++;
            end
         end
         dzr_pkg::PH_FULL: begin
            if (field == 0) begin
               dec_phase = (pixel_pos >= frame_total) ?
                           dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
            end else begin
               literals_left = field;
               dec_phase = dzr_pkg::PH_LIT;
            end
         end
         default: begin
            if (pixel_pos < frame_total) begin
               pixel_pos = pixel_pos + 32'd1;
               run.frame_last = (pixel_pos == frame_total);
            end else begin
               run.overrun_error = 1'b1;
            end
            if (literals_left != 0) literals_left = literals_left - 32'd1;
            if (literals_left == 0)
               dec_phase = (pixel_pos >= frame_total) ?
                           dzr_pkg::PH_WIDTH : dzr_pkg::PH_EMPTY;
            run.depth_value = field[15:0];
            expected_runs = {expected_runs, run};
            runs_predicted++;
         end
      endcase
   endtask

   task automatic push_bytes(input logic [31:0] value, input int nbytes);
      stream_byte_type sb;
      for (int i = 0; i < nbytes; i++) begin
         sb.data = value[8 * i +: 8];
         sb.drain = drain_pending;
         drain_pending = 1'b0;
         stream_q = {stream_q, sb};
      end
   endtask

   // header plus pairs until the frame is covered; literals may run past it
   task automatic gen_frame(input logic [31:0] w, input logic [31:0] h);
      logic [63:0] left;
      logic [31:0] empty_n;
      logic [31:0] full_n;
      logic [31:0] sample;
      int unsigned pick;
      push_bytes(w, 4);
      push_bytes(h, 4);
      left = 64'(w) * 64'(h);
      if (left > 64'hFFFF_FFFF) left = 64'hFFFF_FFFF;
      while (left != 0) begin
         pick = $urandom_range(99, 0);
         if (left > 64'd10000) empty_n = left[31:0];
         else if (pick < 25) empty_n = 32'd0;
         else if (pick < 80) empty_n = $urandom_range(left[31:0], 1);
         else if (pick < 92) empty_n = left[31:0] + $urandom_range(20, 1);
         else empty_n = $urandom() & COUNT_MASK;
         push_bytes(empty_n, dzr_pkg::COUNT_BYTES);
         left = (64'(empty_n) >= left) ? 64'd0 : left - 64'(empty_n);
         pick = $urandom_range(99, 0);
         if (pick < 20) full_n = 32'd0;
         else if (pick < 94) full_n = $urandom_range(6, 1);
         else full_n = $urandom_range(12, 7);
         push_bytes(full_n, dzr_pkg::COUNT_BYTES);
         for (int i = 0; i < full_n; i++) begin
            if ($urandom_range(99, 0) < 20) begin
               case ($urandom_range(3, 0))
                  0:       sample = 32'h8000;
                  1:       sample = 32'h7FFF;
                  2:       sample = 32'h0000;
                  default: sample = 32'hFFFF;
               endcase
            end else begin
               sample = $urandom();
            end
            push_bytes(sample, 2);
         end
         left = (64'(full_n) >= left) ? 64'd0 : left - 64'(full_n);
      end
   endtask

   function automatic int unsigned idle_share(input bit receiver);
      int unsigned stage;
      stage = (stream_total == 0) ? 2 : (bytes_accepted * 3) / stream_total;
      if (stage == 0) return receiver ? 58 : 12;
      if (stage == 1) return receiver ? 12 : 58;
      return 0;
   endfunction

   // byte driver and predictor
   always @(posedge clock) begin
      stream_byte_type nxt;
      int              pending;
      bit              send;
      if (reset) begin
         req_bus.valid <= 1'b0;
         req_bus.data_byte <= '0;
         dec_phase = dzr_pkg::PH_WIDTH;
         dec_index = '0;
         dec_word = '0;
         frame_w = '0;
         frame_total = '0;
         pixel_pos = '0;
         literals_left = '0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            decode_byte(req_bus.data_byte);
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            pending = runs_predicted - runs_checked - int'(rsp_bus.valid && rsp_bus.ready);
            send = stream_q.size() != 0 && !(stream_q[0].drain && pending > 0)
                   && $urandom_range(99, 0) >= idle_share(1'b0);
            if (send) begin
               nxt = stream_q.pop_front();
               req_bus.data_byte <= nxt.data;
            end
            req_bus.valid <= send;
         end
      end
   end

   // run word monitor
   always @(posedge clock) begin
      dzr_pkg::rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            runs_checked <= runs_checked + 1;
            if (expected_runs.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected run word: value %0d count %0d last %b overrun %b",
                           rsp_bus.depth_value, rsp_bus.repeat_count,
                           rsp_bus.frame_last, rsp_bus.overrun_error);
            end else begin
               want = expected_runs.pop_front();
               if (rsp_bus.depth_value !== want.depth_value
                   || rsp_bus.repeat_count !== want.repeat_count
                   || rsp_bus.frame_last !== want.frame_last
                   || rsp_bus.overrun_error !== want.overrun_error) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch: want %0d x%0d l%b o%b, got %0d x%0d l%b o%b",
                              want.depth_value, want.repeat_count, want.frame_last,
                              want.overrun_error, rsp_bus.depth_value, rsp_bus.repeat_count,
                              rsp_bus.frame_last, rsp_bus.overrun_error);
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99, 0) >= idle_share(1'b1));
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
         end
      end
   end

   initial begin
      int unsigned pick;
      req_bus.valid = 1'b0;
      req_bus.data_byte = '0;
      rsp_bus.ready = 1'b0;
      drain_pending = 1'b0;
      stream_total = 0;
      bytes_accepted = 0;
      runs_predicted = 0;
      runs_checked = 0;
      mismatch_count = 0;
      quiet_cycles = 0;

      // 1x2 frame: zero empty count, one literal, then a full-scale empty count
      // clipped to the last pixel, and a literal that lands past the frame
      push_bytes(32'd1, 4);
      push_bytes(32'd2, 4);
      push_bytes(32'd0, dzr_pkg::COUNT_BYTES);
      push_bytes(32'd1, dzr_pkg::COUNT_BYTES);
      push_bytes(32'h8000, 2);
      push_bytes(COUNT_MASK, dzr_pkg::COUNT_BYTES);
      push_bytes(32'd1, dzr_pkg::COUNT_BYTES);
      push_bytes(32'h7FFF, 2);

      drain_pending = 1'b1;
      while (stream_q.size() < STREAM_BYTES) begin
         if ($urandom_range(9, 0) == 0) drain_pending = 1'b1;
         pick = $urandom_range(99, 0);
         if (pick < 6) begin
            if ($urandom_range(1, 0) == 1) gen_frame(32'd0, $urandom());
            else gen_frame($urandom(), 32'd0);
         end else if (pick < 10 && dzr_pkg::COUNT_BYTES == 4) begin
            gen_frame($urandom() | 32'h0001_0000, $urandom() | 32'h0001_0000);
         end else begin
            gen_frame($urandom_range(8, 1), $urandom_range(8, 1));
         end
      end
      stream_total = stream_q.size();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      while (stream_q.size() != 0 || req_bus.valid || expected_runs.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule
